// ===== rtl/core/tct_pkg.sv =====
`timescale 1ns / 1ps
package tct_pkg;

  localparam int CHANNELS    = 32;
  localparam int INSTRUMENTS = 128;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int INST_W      = $clog2(INSTRUMENTS);

  // opcodes
  localparam logic [1:0] OP_CONVERT   = 2'd0;
  localparam logic [1:0] OP_MAP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR     = 2'd2;

  // source note codes
  localparam logic [7:0] NOTE_FIRST   = 8'd1;
  localparam logic [7:0] NOTE_LAST    = 8'd96;
  localparam logic [7:0] NOTE_OFF_SRC = 8'd97;
  localparam logic [7:0] NOTE_OFF_DST = 8'd128;

  localparam logic [7:0] SYNTH_NONE  = 8'd255;
  localparam logic [7:0] SYNTH_LOCAL = 8'd0;
  localparam logic [7:0] SYNTH_SAT   = 8'd254;

  localparam logic [7:0] VOL_LO = 8'h10;
  localparam logic [7:0] VOL_HI = 8'h50;

  // source effect codes
  localparam logic [7:0] FX_ARPEGGIO   = 8'h00;
  localparam logic [7:0] FX_SLIDE_UP   = 8'h01;
  localparam logic [7:0] FX_SLIDE_DOWN = 8'h02;
  localparam logic [7:0] FX_TONE_PORTA = 8'h03;
  localparam logic [7:0] FX_PANNING    = 8'h08;
  localparam logic [7:0] FX_OFFSET     = 8'h09;
  localparam logic [7:0] FX_VOL_SLIDE  = 8'h0A;
  localparam logic [7:0] FX_VOLUME     = 8'h0C;
  localparam logic [7:0] FX_SPEED      = 8'h0F;

  // target controller numbers
  localparam logic [9:0] CTL_NONE      = 10'h000;
  localparam logic [9:0] CTL_ARPEGGIO  = 10'h008;
  localparam logic [9:0] CTL_OFFSET    = 10'h009;
  localparam logic [9:0] CTL_VOL_SLIDE = 10'h00A;
  localparam logic [9:0] CTL_SPEED     = 10'h00F;
  localparam logic [9:0] CTL_PANNING   = 10'h200;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] channel;
    logic [7:0] note_code;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect;
    logic [7:0] param;
  } cell_t;

  typedef struct packed {
    logic [7:0]  note_out;
    logic [7:0]  synth_out;
    logic [8:0]  velocity_out;
    logic [9:0]  controller_out;
    logic [15:0] controller_value;
  } result_t;

  typedef struct packed {
    logic [7:0] last_note;
    logic       has_synth;
  } chan_st_t;

  typedef struct packed {
    logic       mapped;
    logic [7:0] synth;
  } map_rd_t;

endpackage

// ===== rtl/core/tct_ifs.sv =====
`timescale 1ns / 1ps
interface tct_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [4:0] channel;
  logic [7:0] note_code;
  logic [7:0] instrument;
  logic [7:0] volume;
  logic [7:0] effect;
  logic [7:0] param;
  logic [6:0] map_index;
  logic       map_valid;
  logic [7:0] map_synth;

  modport source (
    output valid, opcode, channel, note_code, instrument, volume, effect, param,
           map_index, map_valid, map_synth,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, note_code, instrument, volume, effect, param,
           map_index, map_valid, map_synth,
    output ready
  );
endinterface

interface tct_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  note_out;
  logic [7:0]  synth_out;
  logic [8:0]  velocity_out;
  logic [9:0]  controller_out;
  logic [15:0] controller_value;

  modport source (
    output valid, note_out, synth_out, velocity_out, controller_out, controller_value,
    input  ready
  );
  modport sink (
    input  valid, note_out, synth_out, velocity_out, controller_out, controller_value,
    output ready
  );
endinterface

// ===== rtl/core/tracker_cell_translator.sv =====
`timescale 1ns / 1ps
// channel   dir  beat
// in_chan   in   opcode, channel, cell bytes, instrument map write fields
// out_chan  out  note_out, synth_out, velocity_out, controller_out, controller_value
//
// one beat accepted per cycle unless a convert beat waits for the output register;
// convert path: input register, map read registered beside it, then result register
// map writes and channel clears give no result and never wait on out_chan
// a stalled result holds in the output register while the next cell is computed
// synchronous active-low reset clears the map valid bits and all channel state
module tracker_cell_translator (
  input  logic          clk,
  input  logic          rst_n,
  tct_in_if.sink        in_chan,
  tct_out_if.source     out_chan
);
  import tct_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  cell_t    s1_cell_r;
  logic     out_valid_r, out_valid_nxt;
  result_t  out_res_r;
  logic     in_fire;
  logic     s1_adv;
  logic     s1_convert;
  map_rd_t  map_rd;
  chan_st_t st_rd, st_wr;
  result_t  res;

  assign s1_convert = s1_cell_r.opcode == OP_CONVERT;
  // only a convert beat needs room in the output register
  assign s1_adv     = s1_valid_r && (!s1_convert || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_fire    = in_chan.valid && in_chan.ready;

  tct_inst_map u_map (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_en         (in_fire && in_chan.opcode == OP_MAP_WRITE),
    .wr_index      (in_chan.map_index),
    .wr_valid      (in_chan.map_valid),
    .wr_synth      (in_chan.map_synth),
    .rd_en         (in_fire),
    .rd_instrument (in_chan.instrument),
    .rd_data       (map_rd)
  );

  tct_chan_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .channel   (s1_cell_r.channel),
    .rd_state  (st_rd),
    .upd_en    (s1_adv && s1_convert),
    .upd_state (st_wr),
    .clear     (s1_adv && s1_cell_r.opcode == OP_CLEAR)
  );

  tct_cell_xlate u_xlate (
    .src_cell (s1_cell_r),
    .map_rd   (map_rd),
    .st_in    (st_rd),
    .st_out   (st_wr),
    .res      (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_convert) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cell_r.opcode     <= in_chan.opcode;
      s1_cell_r.channel    <= in_chan.channel;
      s1_cell_r.note_code  <= in_chan.note_code;
      s1_cell_r.instrument <= in_chan.instrument;
      s1_cell_r.volume     <= in_chan.volume;
      s1_cell_r.effect     <= in_chan.effect;
      s1_cell_r.param      <= in_chan.param;
    end
    if (s1_adv && s1_convert) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.note_out         = out_res_r.note_out;
  assign out_chan.synth_out        = out_res_r.synth_out;
  assign out_chan.velocity_out     = out_res_r.velocity_out;
  assign out_chan.controller_out   = out_res_r.controller_out;
  assign out_chan.controller_value = out_res_r.controller_value;

endmodule

// ===== rtl/core/tct_inst_map.sv =====
`timescale 1ns / 1ps
module tct_inst_map (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [6:0]        wr_index,
  input  logic              wr_valid,
  input  logic [7:0]        wr_synth,
  input  logic              rd_en,
  input  logic [7:0]        rd_instrument,
  output tct_pkg::map_rd_t  rd_data
);
  import tct_pkg::*;

  logic [8:0]             mem [INSTRUMENTS];
  logic [INSTRUMENTS-1:0] written_r;
  logic [8:0]             rd_word_r;
  logic                   rd_hit_r;
  logic [7:0]             rd_idx;
  logic                   rd_in_range;
  logic                   wr_in_range;

  // instrument n reads entry n-1; instrument 0 wraps out of range
  assign rd_idx      = rd_instrument - 8'd1;
  assign rd_in_range = (rd_instrument != 8'd0) && (int'(rd_idx) < INSTRUMENTS);
  assign wr_in_range = int'(wr_index) < INSTRUMENTS;

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_index[INST_W-1:0]] <= {wr_valid, wr_synth};
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_idx[INST_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_hit_r  <= 1'b0;
    end else begin
      if (wr_en && wr_in_range) begin
        written_r[wr_index[INST_W-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= rd_in_range && written_r[rd_idx[INST_W-1:0]];
      end
    end
  end

  assign rd_data.mapped = rd_hit_r && rd_word_r[8];
  assign rd_data.synth  = rd_word_r[7:0];

endmodule

// ===== rtl/core/tct_chan_state.sv =====
`timescale 1ns / 1ps
module tct_chan_state (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [4:0]         channel,
  output tct_pkg::chan_st_t  rd_state,
  input  logic               upd_en,
  input  tct_pkg::chan_st_t  upd_state,
  input  logic               clear
);
  import tct_pkg::*;

  chan_st_t state_r [CHANNELS];
  logic     ch_ok;

  assign ch_ok    = int'(channel) < CHANNELS;
  assign rd_state = ch_ok ? state_r[channel[CH_W-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state_r[i] <= '0;
      end
    end else if (upd_en && ch_ok) begin
      state_r[channel[CH_W-1:0]] <= upd_state;
    end
  end

endmodule

// ===== rtl/core/tct_cell_xlate.sv =====
`timescale 1ns / 1ps
module tct_cell_xlate (
  input  tct_pkg::cell_t     src_cell,
  input  tct_pkg::map_rd_t   map_rd,
  input  tct_pkg::chan_st_t  st_in,
  output tct_pkg::chan_st_t  st_out,
  output tct_pkg::result_t   res
);
  import tct_pkg::*;

  logic [7:0]  note;
  logic [7:0]  prev_note;
  logic        has_synth;
  logic [7:0]  synth;
  logic [8:0]  vel;
  logic [9:0]  ctl;
  logic [15:0] val;
  logic [7:0]  vol_ofs;
  logic [8:0]  vol_vel;
  logic [7:0]  vel_m1;
  logic [15:0] vel_prod;

  assign vol_ofs  = src_cell.volume - VOL_LO;
  assign vol_vel  = (src_cell.volume >= VOL_LO && src_cell.volume <= VOL_HI) ?
                    {vol_ofs, 1'b1} : 9'd0;
  assign vel_m1   = vol_vel[7:0] - 8'd1;
  assign vel_prod = 16'(vel_m1) * 16'(src_cell.param);

  always_comb begin
    note      = 8'd0;
    prev_note = st_in.last_note;
    has_synth = st_in.has_synth;
    synth     = SYNTH_LOCAL;
    vel       = vol_vel;
    ctl       = CTL_NONE;
    val       = 16'd0;

    if (src_cell.note_code >= NOTE_FIRST && src_cell.note_code <= NOTE_LAST) begin
      note      = src_cell.note_code;
      prev_note = src_cell.note_code;
    end else if (src_cell.note_code == NOTE_OFF_SRC) begin
      note      = NOTE_OFF_DST;
      prev_note = 8'd0;
    end

    if (src_cell.instrument != 8'd0) begin
      if (!map_rd.mapped) begin
        synth = SYNTH_NONE;
      end else begin
        synth     = (map_rd.synth >= SYNTH_SAT) ? SYNTH_NONE : map_rd.synth + 8'd1;
        has_synth = 1'b1;
        // mapped instrument alone retriggers the last note
        if (note == 8'd0 && prev_note != 8'd0) begin
          note = prev_note;
        end
      end
    end

    unique case (src_cell.effect)
      FX_ARPEGGIO: begin
        if (src_cell.param != 8'd0) begin
          ctl = CTL_ARPEGGIO;
          val = {4'd0, src_cell.param[7:4], 4'd0, src_cell.param[3:0]};
        end
      end
      FX_SLIDE_UP, FX_SLIDE_DOWN, FX_TONE_PORTA: begin
        ctl = {2'd0, src_cell.effect};
        val = {6'd0, src_cell.param, 2'd0};
      end
      FX_PANNING: begin
        if (has_synth) begin
          if (note == 8'd0) begin
            synth = SYNTH_LOCAL;
          end
          ctl = CTL_PANNING;
          val = {1'b0, src_cell.param[7:1], 8'd0};
        end
      end
      FX_OFFSET: begin
        ctl = CTL_OFFSET;
        val = {7'd0, src_cell.param, 1'b0};
      end
      FX_VOL_SLIDE: begin
        ctl = CTL_VOL_SLIDE;
        val = {2'd0, src_cell.param[7:4], 4'd0, src_cell.param[3:0], 2'd0};
      end
      FX_VOLUME: begin
        // product stays below 2^15, so bits 14:6 hold the scaled value
        if (vel == 9'd0) begin
          vel = {src_cell.param, 1'b1};
        end else begin
          vel = vel_prod[14:6] + 9'd1;
        end
      end
      FX_SPEED: begin
        ctl = CTL_SPEED;
        val = {8'd0, src_cell.param};
      end
      default: begin
      end
    endcase
  end

  assign st_out.last_note = prev_note;
  assign st_out.has_synth = has_synth;

  assign res.note_out         = note;
  assign res.synth_out        = synth;
  assign res.velocity_out     = vel;
  assign res.controller_out   = ctl;
  assign res.controller_value = val;

endmodule

// ===== rtl/core/tct_checker.sv =====
`timescale 1ns / 1ps
module tct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  note_out,
  input logic [7:0]  synth_out,
  input logic [8:0]  velocity_out,
  input logic [9:0]  controller_out,
  input logic [15:0] controller_value
);
  import tct_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({note_out, synth_out, velocity_out,
                                         controller_out, controller_value}))
    else $error("stalled result beat changed");

  a_note_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> note_out <= NOTE_LAST || note_out == NOTE_OFF_DST)
    else $error("illegal target note");

  a_no_ctl_no_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && controller_out == CTL_NONE |-> controller_value == 16'd0)
    else $error("controller value without controller");

  a_local_synth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && controller_out == CTL_PANNING && note_out == 8'd0
    |-> synth_out == SYNTH_LOCAL)
    else $error("panning without a note not sent to the local controller");

endmodule

bind tracker_cell_translator tct_checker u_tct_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .note_out         (out_chan.note_out),
  .synth_out        (out_chan.synth_out),
  .velocity_out     (out_chan.velocity_out),
  .controller_out   (out_chan.controller_out),
  .controller_value (out_chan.controller_value)
);

// ===== bench/cell_result_checker.sv =====
`timescale 1ns / 1ps
module cell_result_checker (
  input  logic clk,
  input  logic rst_n,
  tct_in_if    in_mon,
  tct_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  import tct_pkg::*;

  logic [7:0] last_note_q  [CHANNELS];
  logic       synth_seen_q [CHANNELS];
  map_rd_t    inst_map_q   [INSTRUMENTS];

  result_t predicted_cells[$];

  function automatic void clear_channels();
    for (int i = 0; i < CHANNELS; i++) begin
      last_note_q[i]  = 8'd0;
      synth_seen_q[i] = 1'b0;
    end
  endfunction

  // one convert beat: builds the target cell and updates the channel state
  function automatic result_t translate_cell(logic [4:0] ch, logic [7:0] ncode,
                                             logic [7:0] inst, logic [7:0] vol,
                                             logic [7:0] fx, logic [7:0] par);
    result_t    r;
    logic [7:0] prev;
    logic       seen;
    logic [7:0] note;
    logic [7:0] synth;
    logic [9:0] ctl;
    map_rd_t    ent;
    int         vel;
    int         val;
    int         idx;
    bit         ch_ok;
    ch_ok = int'(ch) < CHANNELS;
    prev  = ch_ok ? last_note_q[ch] : 8'd0;
    seen  = ch_ok ? synth_seen_q[ch] : 1'b0;
    note  = 8'd0;
    synth = 8'd0;
    ctl   = CTL_NONE;
    vel   = 0;
    val   = 0;

    if (ncode >= NOTE_FIRST && ncode <= NOTE_LAST) begin
      note = ncode;
      prev = ncode;
    end else if (ncode == NOTE_OFF_SRC) begin
      note = NOTE_OFF_DST;
      prev = 8'd0;
    end

    if (inst != 8'd0) begin
      idx = int'(inst) - 1;
      ent = (idx < INSTRUMENTS) ? inst_map_q[idx] : '0;
      if (!ent.mapped) begin
        synth = SYNTH_NONE;
      end else begin
        synth = (ent.synth >= SYNTH_SAT) ? SYNTH_NONE : ent.synth + 8'd1;
        seen  = 1'b1;
        // mapped instrument without a note retriggers the last note
        if (note == 8'd0 && prev != 8'd0) note = prev;
      end
    end

    if (vol >= VOL_LO && vol <= VOL_HI) vel = (int'(vol) - int'(VOL_LO)) * 2 + 1;

    case (fx)
      FX_ARPEGGIO: begin
        if (par != 8'd0) begin
          ctl = CTL_ARPEGGIO;
          val = int'(par[3:0]) + (int'(par[7:4]) << 8);
        end
      end
      FX_SLIDE_UP, FX_SLIDE_DOWN, FX_TONE_PORTA: begin
        ctl = 10'(fx);
        val = int'(par) * 4;
      end
      FX_PANNING: begin
        if (seen) begin
          if (note < NOTE_FIRST || note > NOTE_OFF_DST) synth = SYNTH_LOCAL;
          ctl = CTL_PANNING;
          val = (int'(par) / 2) << 8;
        end
      end
      FX_OFFSET: begin
        ctl = CTL_OFFSET;
        val = int'(par) * 2;
      end
      FX_VOL_SLIDE: begin
        ctl = CTL_VOL_SLIDE;
        val = ((int'(par[7:4]) * 4) << 8) | (int'(par[3:0]) * 4);
      end
      FX_VOLUME: begin
        if (vel == 0) vel = int'(par) * 2 + 1;
        else vel = ((vel - 1) * int'(par)) / 64 + 1;
      end
      FX_SPEED: begin
        ctl = CTL_SPEED;
        val = int'(par);
      end
      default: ;
    endcase

    if (ch_ok) begin
      last_note_q[ch]  = prev;
      synth_seen_q[ch] = seen;
    end

    r.note_out         = note;
    r.synth_out        = synth;
    r.velocity_out     = 9'(vel);
    r.controller_out   = ctl;
    r.controller_value = 16'(val);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      clear_channels();
      for (int i = 0; i < INSTRUMENTS; i++) inst_map_q[i] = '0;
      predicted_cells.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got.note_out         = out_mon.note_out;
        got.synth_out        = out_mon.synth_out;
        got.velocity_out     = out_mon.velocity_out;
        got.controller_out   = out_mon.controller_out;
        got.controller_value = out_mon.controller_value;
        if (predicted_cells.size() == 0) begin
          $error("unexpected result beat: note_out %0d synth_out %0d", got.note_out,
                 got.synth_out);
          fail_count++;
        end else begin
          want = predicted_cells.pop_front();
          if (got.note_out !== want.note_out) begin
            $error("note_out: expected %0d, got %0d", want.note_out, got.note_out);
            fail_count++;
          end
          if (got.synth_out !== want.synth_out) begin
            $error("synth_out: expected %0d, got %0d", want.synth_out, got.synth_out);
            fail_count++;
          end
          if (got.velocity_out !== want.velocity_out) begin
            $error("velocity_out: expected %0d, got %0d", want.velocity_out,
                   got.velocity_out);
            fail_count++;
          end
          if (got.controller_out !== want.controller_out) begin
            $error("controller_out: expected 0x%0h, got 0x%0h", want.controller_out,
                   got.controller_out);
            fail_count++;
          end
          if (got.controller_value !== want.controller_value) begin
            $error("controller_value: expected 0x%0h, got 0x%0h", want.controller_value,
                   got.controller_value);
            fail_count++;
          end
        end
      end

      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        case (in_mon.opcode)
          OP_CONVERT: begin
            predicted_cells.push_back(translate_cell(in_mon.channel, in_mon.note_code,
                                                     in_mon.instrument, in_mon.volume,
                                                     in_mon.effect, in_mon.param));
          end
          OP_MAP_WRITE: begin
            if (int'(in_mon.map_index) < INSTRUMENTS) begin
              inst_map_q[in_mon.map_index].mapped = in_mon.map_valid;
              inst_map_q[in_mon.map_index].synth  = in_mon.map_synth;
            end
          end
          OP_CLEAR: clear_channels();
          default: ;
        endcase
      end
    end
    pending = predicted_cells.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import tct_pkg::*;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         PHASE_BEATS = 300;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  localparam logic [7:0] FX_LIST [9] = '{FX_ARPEGGIO, FX_SLIDE_UP, FX_SLIDE_DOWN,
                                         FX_TONE_PORTA, FX_PANNING, FX_OFFSET,
                                         FX_VOL_SLIDE, FX_VOLUME, FX_SPEED};

  typedef struct {
    logic [1:0] opcode;
    logic [4:0] channel;
    logic [7:0] note_code;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect;
    logic [7:0] param;
    logic [6:0] map_index;
    logic       map_valid;
    logic [7:0] map_synth;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   fail_count;
  int   pending;
  int   cycle_cnt;

  tct_in_if  in_chan ();
  tct_out_if out_chan ();

  tracker_cell_translator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  cell_result_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic beat_t cell_beat(logic [4:0] ch, logic [7:0] ncode, logic [7:0] inst,
                                      logic [7:0] vol, logic [7:0] fx, logic [7:0] par);
    beat_t b;
    b.opcode     = OP_CONVERT;
    b.channel    = ch;
    b.note_code  = ncode;
    b.instrument = inst;
    b.volume     = vol;
    b.effect     = fx;
    b.param      = par;
    b.map_index  = 7'd0;
    b.map_valid  = 1'b0;
    b.map_synth  = 8'd0;
    return b;
  endfunction

  function automatic beat_t map_beat(logic [6:0] idx, logic mvalid, logic [7:0] msynth);
    beat_t b;
    b           = cell_beat(5'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    b.opcode    = OP_MAP_WRITE;
    b.map_index = idx;
    b.map_valid = mvalid;
    b.map_synth = msynth;
    return b;
  endfunction

  task automatic send_beat(input beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.opcode     <= b.opcode;
    in_chan.channel    <= b.channel;
    in_chan.note_code  <= b.note_code;
    in_chan.instrument <= b.instrument;
    in_chan.volume     <= b.volume;
    in_chan.effect     <= b.effect;
    in_chan.param      <= b.param;
    in_chan.map_index  <= b.map_index;
    in_chan.map_valid  <= b.map_valid;
    in_chan.map_synth  <= b.map_synth;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
  endtask

  initial begin
    beat_t b;
    int    sel;
    rst_n              = 1'b0;
    tx_idle_pct        = 25;
    rx_idle_pct        = 79;
    in_chan.valid      = 1'b0;
    in_chan.opcode     = OP_CONVERT;
    in_chan.channel    = 5'd0;
    in_chan.note_code  = 8'd0;
    in_chan.instrument = 8'd0;
    in_chan.volume     = 8'd0;
    in_chan.effect     = 8'd0;
    in_chan.param      = 8'd0;
    in_chan.map_index  = 7'd0;
    in_chan.map_valid  = 1'b0;
    in_chan.map_synth  = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: map extremes, every effect, note retrigger, local controller, clears
    send_beat(map_beat(7'd0, 1'b1, 8'd5));
    send_beat(map_beat(7'd127, 1'b1, 8'd255));
    send_beat(map_beat(7'd1, 1'b1, 8'd254));
    send_beat(map_beat(7'd2, 1'b0, 8'd77));
    send_beat(cell_beat(5'd0, 8'd1, 8'd1, VOL_LO, FX_ARPEGGIO, 8'h00));
    send_beat(cell_beat(5'd31, 8'd96, 8'd128, VOL_HI, FX_ARPEGGIO, 8'hff));
    send_beat(cell_beat(5'd0, 8'd0, 8'd1, 8'd0, FX_PANNING, 8'hff));
    send_beat(cell_beat(5'd1, 8'd0, 8'd2, 8'd0, FX_PANNING, 8'h40));
    send_beat(cell_beat(5'd2, NOTE_OFF_SRC, 8'd3, 8'h0f, FX_SLIDE_UP, 8'hff));
    send_beat(cell_beat(5'd2, 8'd98, 8'd129, 8'h51, FX_SLIDE_DOWN, 8'h00));
    send_beat(cell_beat(5'd3, 8'd0, 8'd255, 8'd0, FX_PANNING, 8'h10));
    send_beat(cell_beat(5'd3, 8'd50, 8'd0, 8'h30, FX_TONE_PORTA, 8'h80));
    send_beat(cell_beat(5'd4, 8'd12, 8'd4, 8'd0, FX_OFFSET, 8'hff));
    send_beat(cell_beat(5'd5, 8'd13, 8'd1, 8'd0, FX_VOL_SLIDE, 8'hff));
    send_beat(cell_beat(5'd6, 8'd0, 8'd0, 8'd0, FX_VOLUME, 8'hff));
    send_beat(cell_beat(5'd6, 8'd0, 8'd0, VOL_HI, FX_VOLUME, 8'hff));
    send_beat(cell_beat(5'd7, 8'd0, 8'd0, 8'h20, FX_VOLUME, 8'h00));
    send_beat(cell_beat(5'd8, 8'd24, 8'd0, 8'd0, FX_SPEED, 8'ha5));
    send_beat(cell_beat(5'd9, 8'd24, 8'd1, 8'd0, 8'h55, 8'h5a));
    b        = map_beat(7'd0, 1'b0, 8'hff);
    b.opcode = OP_UNUSED;
    send_beat(b);
    send_beat(cell_beat(5'd0, 8'd0, 8'd1, 8'd0, FX_ARPEGGIO, 8'h5a));
    b        = map_beat(7'd0, 1'b0, 8'd0);
    b.opcode = OP_CLEAR;
    send_beat(b);
    send_beat(cell_beat(5'd0, 8'd0, 8'd1, 8'd0, FX_PANNING, 8'h7f));
    send_beat(cell_beat(5'd31, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 25; rx_idle_pct = 79; end
        1: begin tx_idle_pct = 79; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      repeat (PHASE_BEATS) begin
        sel = $urandom_range(99);
        if (sel < 76) b.opcode = OP_CONVERT;
        else if (sel < 90) b.opcode = OP_MAP_WRITE;
        else if (sel < 95) b.opcode = OP_CLEAR;
        else b.opcode = OP_UNUSED;
        // a few busy channels so notes and synth flags carry over
        b.channel = $urandom_range(1) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
        case ($urandom_range(9))
          0, 1, 2, 3, 4: b.note_code = 8'($urandom_range(96, 1));
          5:             b.note_code = NOTE_OFF_SRC;
          6, 7:          b.note_code = 8'd0;
          default:       b.note_code = 8'($urandom_range(255));
        endcase
        case ($urandom_range(9))
          0, 1:          b.instrument = 8'd0;
          2, 3, 4, 5, 6: b.instrument = 8'($urandom_range(8, 1));
          7:             b.instrument = 8'($urandom_range(128, 1));
          8:             b.instrument = 8'($urandom_range(255, 129));
          default:       b.instrument = 8'($urandom_range(255));
        endcase
        b.volume = $urandom_range(1) ? 8'($urandom_range(int'(VOL_HI), int'(VOL_LO)))
                                     : 8'($urandom_range(255));
        b.effect = ($urandom_range(3) != 0) ? FX_LIST[$urandom_range(8)]
                                            : 8'($urandom_range(255));
        b.param     = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255));
        b.map_index = $urandom_range(1) ? 7'($urandom_range(7)) : 7'($urandom_range(127));
        b.map_valid = ($urandom_range(3) != 0);
        b.map_synth = 8'($urandom_range(255));
        send_beat(b);
      end
    end

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
